// ===== rtl/arpc_pkg.sv =====
// Shared types, codes and defaults for the audio record/playback controller.
package arpc_pkg;

    localparam int STORE_DEPTH_DEF = 65536;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam int POS_W   = 17;
    localparam int START_W = 16;
    localparam int REQ_W   = 2;
    localparam int MODE_W  = 2;
    localparam int IN_W    = 32;

    localparam logic [POS_W-1:0] POS_MAX   = '1;
    localparam logic [POS_W-1:0] END_RESET = 17'h10000;

    localparam logic [REQ_W-1:0] REQ_PLAY = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REC  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    localparam logic [MODE_W-1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_PLAY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_REC  = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_PLAY = 3'b010,
        MODE_REC  = 3'b100
    } t_mode;

    typedef struct packed {
        logic              play;
        logic [MODE_W-1:0] mode;
    } t_item_info;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        unique case (m)
            MODE_PLAY: c = MODE_CODE_PLAY;
            MODE_REC:  c = MODE_CODE_REC;
            default:   c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/arpc_ram.sv =====
// Generic single-port RAM with registered read data.
module arpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/arpc_ctrl.sv =====
// Mode and position sequencer with store addressing and start slot reduction.
module arpc_ctrl #(
    parameter int STORE_DEPTH = arpc_pkg::STORE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [arpc_pkg::REQ_W-1:0]         i_req_type,
    input  logic                               i_cfg_wr,
    input  logic                               i_cfg_index,
    input  logic [arpc_pkg::POS_W-1:0]         i_cfg_data,
    output logic                               o_busy,
    output logic                               o_mem_en,
    output logic                               o_mem_we,
    output logic [$clog2(STORE_DEPTH)-1:0]     o_mem_addr,
    output arpc_pkg::t_item_info               o_info
);

    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int MUL_SH = arpc_pkg::START_W + AW;
    localparam int RCP_W  = arpc_pkg::START_W + 2;
    localparam int PROD_W = arpc_pkg::START_W + RCP_W;
    localparam longint RCP_VAL = ((longint'(1) << MUL_SH) + longint'(STORE_DEPTH) - 1)
                                 / longint'(STORE_DEPTH);
    localparam logic [RCP_W-1:0]              RECIP     = RCP_W'(RCP_VAL);
    localparam logic [arpc_pkg::START_W-1:0]  DEPTH_LO  = arpc_pkg::START_W'(STORE_DEPTH);
    localparam logic [AW-1:0]                 SLOT_LAST = AW'(STORE_DEPTH - 1);

    logic [arpc_pkg::START_W-1:0] r_start, n_start;
    logic [arpc_pkg::POS_W-1:0]   r_end, n_end;
    logic [arpc_pkg::START_W-1:0] r_rem, n_rem;
    logic [arpc_pkg::START_W-1:0] r_quo, n_quo;
    logic                         r_step, n_step;
    logic                         r_busy, n_busy;
    arpc_pkg::t_mode              r_mode, n_mode;
    logic [arpc_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [AW-1:0]                r_slot, n_slot;

    logic [PROD_W-1:0]            prod;
    logic [arpc_pkg::POS_W-1:0]   pos_inc;
    logic [AW-1:0]                slot_inc;
    logic                         tick, moving;

    always_comb begin
        prod    = PROD_W'(r_rem) * PROD_W'(RECIP);
        n_start = r_start;
        n_end   = r_end;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_step  = r_step;
        n_busy  = r_busy;
        if (r_busy) begin
            if (r_step) begin
                n_quo  = arpc_pkg::START_W'(prod >> MUL_SH);
                n_step = 1'b0;
            end else begin
                n_rem  = r_rem - arpc_pkg::START_W'(r_quo * DEPTH_LO);
                n_busy = 1'b0;
            end
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                arpc_pkg::CFG_START: begin
                    n_start = i_cfg_data[arpc_pkg::START_W-1:0];
                    n_rem   = i_cfg_data[arpc_pkg::START_W-1:0];
                    n_step  = 1'b1;
                    n_busy  = 1'b1;
                end
                arpc_pkg::CFG_END: begin
                    n_end = i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        tick     = i_accept && (i_req_type == arpc_pkg::REQ_TICK);
        moving   = (r_mode == arpc_pkg::MODE_PLAY) || (r_mode == arpc_pkg::MODE_REC);
        pos_inc  = r_pos + 1'b1;
        slot_inc = (r_pos == arpc_pkg::POS_MAX || r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_slot   = r_slot;
        if (i_accept) begin
            priority case (i_req_type)
                arpc_pkg::REQ_PLAY: begin
                    n_mode = arpc_pkg::MODE_PLAY;
                    n_pos  = arpc_pkg::POS_W'(r_start);
                    n_slot = AW'(r_rem);
                end
                arpc_pkg::REQ_REC: begin
                    n_mode = arpc_pkg::MODE_REC;
                    n_pos  = arpc_pkg::POS_W'(r_start);
                    n_slot = AW'(r_rem);
                end
                arpc_pkg::REQ_TICK: begin
                    if (moving) begin
                        n_pos  = pos_inc;
                        n_slot = slot_inc;
                    end
                    if (n_pos >= r_end) begin
                        n_pos  = arpc_pkg::POS_W'(r_start);
                        n_slot = AW'(r_rem);
                        unique case (r_mode)
                            arpc_pkg::MODE_REC:  n_mode = arpc_pkg::MODE_PLAY;
                            arpc_pkg::MODE_PLAY: n_mode = arpc_pkg::MODE_IDLE;
                            default:             n_mode = arpc_pkg::MODE_IDLE;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= arpc_pkg::END_RESET;
            r_rem   <= '0;
            r_quo   <= '0;
            r_step  <= 1'b0;
            r_busy  <= 1'b0;
            r_mode  <= arpc_pkg::MODE_IDLE;
            r_pos   <= '0;
            r_slot  <= '0;
        end else begin
            r_start <= n_start;
            r_end   <= n_end;
            r_rem   <= n_rem;
            r_quo   <= n_quo;
            r_step  <= n_step;
            r_busy  <= n_busy;
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_slot  <= n_slot;
        end
    end

    assign o_busy      = r_busy;
    assign o_mem_en    = tick && moving;
    assign o_mem_we    = r_mode == arpc_pkg::MODE_REC;
    assign o_mem_addr  = r_slot;
    assign o_info.play = tick && (r_mode == arpc_pkg::MODE_PLAY);
    assign o_info.mode = arpc_pkg::mode_code(n_mode);

endmodule

// ===== rtl/audio_record_playback_controller.sv =====
// Top level: sample store, sequencer and result pipeline of the recorder/player.
// A result is valid once its item has passed the store read stage and output register.
// Throughput: one item per cycle (single store port, output register) unless stalled.
// A start_index write runs a slot reduction; input and config stall meanwhile.
// Synchronous active-low reset: idle mode, position 0, start 0, end 65536, pipe empty.
// Store contents are not cleared by reset.
module audio_record_playback_controller #(
    parameter int STORE_DEPTH = arpc_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = arpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [arpc_pkg::REQ_W-1:0]    i_req_type,
    input  logic [arpc_pkg::IN_W-1:0]     i_sample_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [SAMPLE_BITS-1:0]        o_sample_out,
    output logic                          o_sample_valid,
    output logic [arpc_pkg::MODE_W-1:0]   o_mode_now,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [arpc_pkg::POS_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic                 busy, accept, s1_adv;
    logic                 mem_en, mem_we;
    logic [AW-1:0]        mem_addr;
    logic [SAMPLE_BITS-1:0] rdata;
    arpc_pkg::t_item_info info;

    logic                 r_s1_vld;
    arpc_pkg::t_item_info r_s1_info;
    logic                 r_out_vld;
    logic [SAMPLE_BITS-1:0] r_out_smp;
    logic                 r_out_play;
    logic [arpc_pkg::MODE_W-1:0] r_out_mode;

    assign s1_adv      = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !busy && (!r_s1_vld || s1_adv);
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = !busy;

    arpc_ctrl #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (i_req_type),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_mem_en    (mem_en),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_addr),
        .o_info      (info)
    );

    arpc_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_sample_in[SAMPLE_BITS-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info <= info;
        end
        if (s1_adv) begin
            r_out_smp  <= r_s1_info.play ? rdata : '0;
            r_out_play <= r_s1_info.play;
            r_out_mode <= r_s1_info.mode;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_sample_out   = r_out_smp;
    assign o_sample_valid = r_out_play;
    assign o_mode_now     = r_out_mode;

endmodule
